// File: rtl/lfucd_pkg.sv
`timescale 1ns / 1ps
package lfucd_pkg;

    localparam int LINES      = 4;
    localparam int COUNT_BITS = 16;
    localparam int TAG_BITS   = 6;
    localparam int WORD_BITS  = 2;
    localparam int IDX_FIELD  = 2;
    localparam int TOTAL_BITS = 32;
    localparam int LINE_BITS  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CMP_BITS   = (COUNT_BITS > TAG_BITS) ? COUNT_BITS : TAG_BITS;

    typedef struct packed {
        logic                  valid;
        logic [TAG_BITS-1:0]   tag;
        logic [COUNT_BITS-1:0] count;
    } line_t;

    typedef struct packed {
        logic                  en;
        logic [LINE_BITS-1:0]  idx;
        logic [TAG_BITS-1:0]   tag;
        logic [COUNT_BITS-1:0] count;
    } line_wr_t;

    // Fit a line number into the two-bit result field: mask or zero-extend.
    function automatic logic [IDX_FIELD-1:0] to_idx_field(input logic [LINE_BITS-1:0] idx);
        logic [IDX_FIELD-1:0] f;
        f = '0;
        for (int i = 0; i < IDX_FIELD; i++)
        begin
            if (i < LINE_BITS)
                f[i] = idx[i];
        end
        return f;
    endfunction

endpackage

// File: rtl/lfu_fully_associative_cache_directory_core.sv
`timescale 1ns / 1ps
// Tag directory of a fully associative cache with least-frequently-used
// replacement. Each input beat (block_tag, word_offset) is one access; each
// output beat gives hit, line_index, word_index and the running hit and miss
// totals. An external data RAM is addressed with line_index and word_index.
// Both channels are valid/ready. One access is worked at a time: a single
// comparator walks the lines for a tag match (one line a cycle, stopping at
// the first match), and on a miss walks them again for the lowest use count.
// A hit goes from the tag walk straight to the update step; a miss passes
// through the count walk first. in_ready is high only when no access
// is being worked, so the next beat can be taken while the last result still
// sits in the output register. If the receiver stalls, the finished access
// waits in its update step and the directory is left untouched until the
// output register frees. Reset empties every line, clears use counts and
// totals, and leaves the block ready with no output pending.
module lfu_fully_associative_cache_directory_core
    import lfucd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TAG_BITS-1:0]   block_tag,
    input  logic [WORD_BITS-1:0]  word_offset,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output logic [IDX_FIELD-1:0]  line_index,
    output logic [WORD_BITS-1:0]  word_index,
    output logic [TOTAL_BITS-1:0] hit_total,
    output logic [TOTAL_BITS-1:0] miss_total
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TAG  = 2'd1;
    localparam logic [1:0] S_MIN  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    localparam logic [LINE_BITS-1:0] LAST_IDX = LINE_BITS'(LINES - 1);

    logic [1:0]            state_reg, state_next;
    logic [LINE_BITS-1:0]  idx_reg, idx_next;
    logic [LINE_BITS-1:0]  sel_reg, sel_next;
    logic [COUNT_BITS-1:0] least_reg, least_next;
    logic                  found_reg, found_next;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [WORD_BITS-1:0]  word_reg;
    logic [TOTAL_BITS-1:0] hits_reg, hits_next;
    logic [TOTAL_BITS-1:0] misses_reg, misses_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg;
    logic [IDX_FIELD-1:0]  line_index_reg;
    logic [WORD_BITS-1:0]  word_index_reg;

    line_t                 rd_line;
    line_wr_t              wr;
    logic [CMP_BITS-1:0]   cmp_a, cmp_b;
    logic                  cmp_eq, cmp_lt;
    logic                  in_beat, upd_go;

    lfucd_line_file u_lines
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (idx_reg),
        .rd_line (rd_line),
        .wr      (wr)
    );

    // Shared comparator: tags while matching, counts while seeking the victim.
    always_comb
    begin
        if (state_reg == S_MIN)
        begin
            cmp_a = CMP_BITS'(rd_line.count);
            cmp_b = CMP_BITS'(least_reg);
        end
        else
        begin
            cmp_a = CMP_BITS'(rd_line.tag);
            cmp_b = CMP_BITS'(tag_reg);
        end
    end

    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_lt = (cmp_a < cmp_b);

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign upd_go   = (state_reg == S_UPD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sel_next       = sel_reg;
        least_next     = least_reg;
        found_next     = found_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        out_valid_next = out_valid_reg;
        wr             = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_TAG;
                end
            end
            S_TAG:
            begin
                if (rd_line.valid && cmp_eq)
                begin
                    found_next = 1'b1;
                    sel_next   = idx_reg;
                    least_next = rd_line.count;
                    state_next = S_UPD;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_MIN;
                end
                else
                begin
                    idx_next = LINE_BITS'(idx_reg + 1'b1);
                end
            end
            S_MIN:
            begin
                // First line seeds the minimum; later ones replace it only when strictly lower.
                if (idx_reg == '0 || cmp_lt)
                begin
                    least_next = rd_line.count;
                    sel_next   = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                    state_next = S_UPD;
                else
                    idx_next = LINE_BITS'(idx_reg + 1'b1);
            end
            S_UPD:
            begin
                if (upd_go)
                begin
                    wr.en  = 1'b1;
                    wr.idx = sel_reg;
                    wr.tag = tag_reg;
                    if (found_reg)
                    begin
                        // Hold the count once saturated.
                        wr.count  = (&least_reg) ? least_reg
                                                 : COUNT_BITS'(least_reg + 1'b1);
                        hits_next = TOTAL_BITS'(hits_reg + 1'b1);
                    end
                    else
                    begin
                        wr.count    = COUNT_BITS'(1);
                        misses_next = TOTAL_BITS'(misses_reg + 1'b1);
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            sel_reg       <= '0;
            least_reg     <= '0;
            found_reg     <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sel_reg       <= sel_next;
            least_reg     <= least_next;
            found_reg     <= found_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            tag_reg  <= block_tag;
            word_reg <= word_offset;
        end
        if (upd_go)
        begin
            hit_reg        <= found_reg;
            line_index_reg <= to_idx_field(sel_reg);
            word_index_reg <= word_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign line_index = line_index_reg;
    assign word_index = word_index_reg;
    assign hit_total  = hits_reg;
    assign miss_total = misses_reg;

    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == S_TAG) && (idx_reg == '0) && !found_reg)
        else $error("scan did not start from line zero");

    a_one_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> TOTAL_BITS'(hits_reg + misses_reg)
                   == TOTAL_BITS'($past(hits_reg + misses_reg) + 1'b1))
        else $error("totals did not advance by exactly one");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("update step did not present a result");

    a_totals_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !upd_go |=> $stable(hits_reg) && $stable(misses_reg))
        else $error("totals moved outside the update step");

    a_stall_holds_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) && out_valid_reg && !out_ready |-> !wr.en)
        else $error("directory written while result stalled");

endmodule

// File: rtl/lfucd_line_file.sv
`timescale 1ns / 1ps
module lfucd_line_file
    import lfucd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [LINE_BITS-1:0] rd_idx,
    output line_t                rd_line,
    input  line_wr_t             wr
);

    line_t lines_reg [LINES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
                lines_reg[i] <= '0;
        end
        else if (wr.en)
        begin
            lines_reg[wr.idx] <= '{valid: 1'b1, tag: wr.tag, count: wr.count};
        end
    end

    assign rd_line = lines_reg[rd_idx];

endmodule
